// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker of the makespan block.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define FSMK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define FSMK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fsmk_pkg.sv =====
// Package of the flow-shop makespan block: field widths, defaults, types.
// No dependencies; every module of the block but fsmk_ram imports it.
package fsmk_pkg;

    localparam int MAX_JOBS_DEF     = 64;
    localparam int MAX_MACHINES_DEF = 16;
    localparam int TIME_BITS_DEF    = 16;

    localparam int JOB_FIELD_W  = 6;
    localparam int MACH_FIELD_W = 4;
    localparam int TIME_FIELD_W = 16;
    localparam int MIU_W        = 5;
    localparam int ROW_BITS     = 23;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_MIU    = 0;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [MIU_W-1:0]    MIU_RESET = MIU_W'(16);
    localparam logic [ROW_BITS-1:0] ROW_MAX   = '1;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_JOB   = 1'b1
    } t_func;

    typedef struct packed {
        t_func func;
        logic  first;
        logic  last;
    } t_cmd_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_back_state;

endpackage

// ===== rtl/core/fsmk_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module fsmk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fsmk_front.sv =====
// Front end: accepts input transfers, wraps indices, forms table addresses
// and holds decoded commands in a short queue. Depends on fsmk_pkg.
module fsmk_front #(
    parameter int MAX_JOBS     = fsmk_pkg::MAX_JOBS_DEF,
    parameter int MAX_MACHINES = fsmk_pkg::MAX_MACHINES_DEF,
    parameter int TIME_BITS    = fsmk_pkg::TIME_BITS_DEF,
    localparam int ADDR_W      = $clog2(MAX_JOBS * MAX_MACHINES)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [fsmk_pkg::JOB_FIELD_W-1:0]  i_job,
    input  logic [fsmk_pkg::MACH_FIELD_W-1:0] i_machine,
    input  logic [fsmk_pkg::TIME_FIELD_W-1:0] i_time_value,
    input  logic                              i_first_in_sequence,
    input  logic                              i_last_in_sequence,
    output logic                              o_q_vld,
    output fsmk_pkg::t_cmd_ctl                o_q_ctl,
    output logic [ADDR_W-1:0]                 o_q_addr,
    output logic [TIME_BITS-1:0]              o_q_time,
    input  logic                              i_q_pop
);
    import fsmk_pkg::*;

    localparam int JOB_W   = $clog2(MAX_JOBS);
    localparam int MACH_W  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int JOB_VALS  = 2 ** JOB_FIELD_W;
    localparam int MACH_VALS = 2 ** MACH_FIELD_W;

    logic [JOB_W-1:0]  w_job_tab  [JOB_VALS];
    logic [MACH_W-1:0] w_mach_tab [MACH_VALS];
    logic [JOB_W-1:0]  w_job_idx;
    logic [MACH_W-1:0] w_mach_idx;
    logic [ADDR_W-1:0] w_base;
    logic [ADDR_W-1:0] w_addr;
    t_cmd_ctl          w_ctl;
    logic              w_push;

    t_cmd_ctl           r_q_ctl  [QUEUE_DEPTH];
    logic [ADDR_W-1:0]  r_q_addr [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] r_q_time [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    // Index wrap tables, worked out at elaboration.
    for (genvar gi = 0; gi < JOB_VALS; gi++) begin : g_job_wrap
        localparam int JM = gi % MAX_JOBS;
        assign w_job_tab[gi] = JOB_W'(JM);
    end
    for (genvar gm = 0; gm < MACH_VALS; gm++) begin : g_mach_wrap
        localparam int MM = gm % MAX_MACHINES;
        assign w_mach_tab[gm] = MACH_W'(MM);
    end

    always_comb begin
        w_job_idx  = w_job_tab[i_job];
        w_mach_idx = w_mach_tab[i_machine];
        w_base     = ADDR_W'(w_job_idx) * ADDR_W'(MAX_MACHINES);
        w_ctl.func  = t_func'(i_func);
        w_ctl.first = i_first_in_sequence;
        w_ctl.last  = i_last_in_sequence;
        // A job command carries the row base; the back end adds the machine.
        if (w_ctl.func == FUNC_WRITE) begin
            w_addr = w_base + ADDR_W'(w_mach_idx);
        end else begin
            w_addr = w_base;
        end
    end

    assign o_in_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_vld    = (r_count != '0);
    assign o_q_ctl    = r_q_ctl[r_rd_ptr];
    assign o_q_addr   = r_q_addr[r_rd_ptr];
    assign o_q_time   = r_q_time[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_ctl[r_wr_ptr]  <= w_ctl;
            r_q_addr[r_wr_ptr] <= w_addr;
            r_q_time[r_wr_ptr] <= TIME_BITS'(i_time_value);
        end
    end

endmodule

// ===== rtl/core/fsmk_back.sv =====
// Back end: stores processing times and walks the completion row one
// machine per cycle. Depends on fsmk_pkg and fsmk_ram.
module fsmk_back #(
    parameter int MAX_JOBS     = fsmk_pkg::MAX_JOBS_DEF,
    parameter int MAX_MACHINES = fsmk_pkg::MAX_MACHINES_DEF,
    parameter int TIME_BITS    = fsmk_pkg::TIME_BITS_DEF,
    localparam int ADDR_W      = $clog2(MAX_JOBS * MAX_MACHINES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_vld,
    input  fsmk_pkg::t_cmd_ctl            i_q_ctl,
    input  logic [ADDR_W-1:0]             i_q_addr,
    input  logic [TIME_BITS-1:0]          i_q_time,
    output logic                          o_q_pop,
    input  logic [fsmk_pkg::MIU_W-1:0]    i_miu,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fsmk_pkg::ROW_BITS-1:0] o_makespan
);
    import fsmk_pkg::*;

    localparam int MACH_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CNT_W  = $clog2(MAX_MACHINES + 1);
    localparam int SUM_W  = ((ROW_BITS > TIME_BITS) ? ROW_BITS : TIME_BITS) + 1;

    t_back_state r_state;
    t_back_state n_state;

    logic [ADDR_W-1:0]   r_base;
    logic                r_last;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_rd_idx;
    logic [CNT_W-1:0]    r_cmp_idx;
    logic                r_pend;
    logic [ROW_BITS-1:0] r_prev;
    logic [MAX_MACHINES-1:0] r_row_vld;
    logic                r_out_vld;
    logic [ROW_BITS-1:0] r_makespan;

    logic [CNT_W-1:0]    w_mcount;
    logic                w_pop;
    logic                w_start;
    logic                w_issue;
    logic                w_done;
    logic                w_slot_free;
    logic                w_load_out;

    logic                w_tab_we;
    logic [ADDR_W-1:0]   w_tab_raddr;
    logic [TIME_BITS-1:0] w_tab_rdata;
    logic                w_row_we;
    logic [MACH_W-1:0]   w_row_raddr;
    logic [ROW_BITS-1:0] w_row_rdata;

    logic [ROW_BITS-1:0] w_up;
    logic [ROW_BITS-1:0] w_max;
    logic [SUM_W-1:0]    w_sum;
    logic [ROW_BITS-1:0] w_v;

    // Machine count clamped to one .. MAX_MACHINES.
    always_comb begin
        if (i_miu == '0) begin
            w_mcount = CNT_W'(1);
        end else if (32'(i_miu) > 32'(MAX_MACHINES)) begin
            w_mcount = CNT_W'(MAX_MACHINES);
        end else begin
            w_mcount = CNT_W'(i_miu);
        end
    end

    assign w_pop       = (r_state == ST_IDLE) && i_q_vld;
    assign w_start     = w_pop && (i_q_ctl.func == FUNC_JOB);
    assign w_issue     = (r_state == ST_WALK) && (r_rd_idx < r_cnt);
    assign w_done      = (r_state == ST_WALK) && r_pend
                         && (r_cmp_idx == r_cnt - CNT_W'(1));
    assign w_slot_free = !r_out_vld || i_out_ready;
    assign w_load_out  = (r_state == ST_EMIT) && w_slot_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_done) begin
                    n_state = r_last ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory controls.
    always_comb begin
        o_q_pop  = w_pop;
        w_tab_we = w_pop && (i_q_ctl.func == FUNC_WRITE);
        w_row_we = (r_state == ST_WALK) && r_pend;
        case (r_state)
            ST_IDLE: begin
                w_tab_raddr = i_q_addr;
                w_row_raddr = '0;
            end
            default: begin
                w_tab_raddr = r_base + ADDR_W'(r_rd_idx);
                w_row_raddr = r_rd_idx[MACH_W-1:0];
            end
        endcase
    end

    // One max-and-add step with saturation.
    always_comb begin
        w_up  = r_row_vld[r_cmp_idx[MACH_W-1:0]] ? w_row_rdata : '0;
        w_max = (w_up > r_prev) ? w_up : r_prev;
        w_sum = SUM_W'(w_max) + SUM_W'(w_tab_rdata);
        w_v   = (w_sum > SUM_W'(ROW_MAX)) ? ROW_MAX : w_sum[ROW_BITS-1:0];
    end

    fsmk_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_JOBS * MAX_MACHINES)
    ) u_time_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (i_q_addr),
        .i_wdata (i_q_time),
        .i_raddr (w_tab_raddr),
        .o_rdata (w_tab_rdata)
    );

    fsmk_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_MACHINES)
    ) u_row (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_cmp_idx[MACH_W-1:0]),
        .i_wdata (w_v),
        .i_raddr (w_row_raddr),
        .o_rdata (w_row_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= 1'b0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= w_start || w_issue;
            if (w_start && i_q_ctl.first) begin
                r_row_vld <= '0;
            end else if (w_row_we) begin
                r_row_vld[r_cmp_idx[MACH_W-1:0]] <= 1'b1;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_base    <= i_q_addr;
            r_last    <= i_q_ctl.last;
            r_cnt     <= w_mcount;
            r_rd_idx  <= CNT_W'(1);
            r_cmp_idx <= '0;
            r_prev    <= '0;
        end else begin
            if (w_issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (w_row_we) begin
                r_cmp_idx <= r_cmp_idx + CNT_W'(1);
                r_prev    <= w_v;
            end
        end
        if (w_load_out) begin
            r_makespan <= r_prev;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_makespan  = r_makespan;

endmodule

// ===== rtl/core/flow_shop_makespan.sv =====
// Top level of the permutation flow-shop makespan evaluator.
// Depends on fsmk_pkg, fsmk_front, fsmk_back and fsmk_ram.
//
// Use: the input channel (i_in_valid / o_in_ready) carries one item per transfer. An item
// with i_func low writes one processing time for the pair (i_job, i_machine); an item with
// i_func high is the next job of a sequence. The output channel (o_out_valid / i_out_ready)
// carries one makespan per job item that has i_last_in_sequence set. The machine count
// sits in an APB register at byte address 0; the user must change it only while the block is
// idle, as the block itself does not enforce this. Flow: a transfer enters a two-entry
// command queue, which the back end drains. A write item is stored in the time table as
// the idle back end takes it from the queue. A job item is taken in a start step, after
// which the single max-and-add unit walks the row through each machine in use in turn; a
// job item that ends a sequence then waits for a free result register and loads it. The back
// end takes no new item from the queue until the item in hand is done.
// Reset: synchronous and active low; it empties the queue, marks the whole completion row
// as zero and sets the machine count to sixteen. The time table holds nothing until written.
// Stall: while the result register is full and not taken, the back end holds the next finished
// makespan and stops; the queue then fills and drops o_in_ready.
module flow_shop_makespan #(
    parameter int MAX_JOBS     = fsmk_pkg::MAX_JOBS_DEF,
    parameter int MAX_MACHINES = fsmk_pkg::MAX_MACHINES_DEF,
    parameter int TIME_BITS    = fsmk_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input channel.
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [fsmk_pkg::JOB_FIELD_W-1:0]  i_job,
    input  logic [fsmk_pkg::MACH_FIELD_W-1:0] i_machine,
    input  logic [fsmk_pkg::TIME_FIELD_W-1:0] i_time_value,
    input  logic                              i_first_in_sequence,
    input  logic                              i_last_in_sequence,
    // Output channel.
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [fsmk_pkg::ROW_BITS-1:0]     o_makespan,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fsmk_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fsmk_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fsmk_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import fsmk_pkg::*;

    localparam int ADDR_W = $clog2(MAX_JOBS * MAX_MACHINES);

    logic [MIU_W-1:0]     r_miu;
    logic                 w_cfg_wr;
    logic                 w_q_vld;
    t_cmd_ctl             w_q_ctl;
    logic [ADDR_W-1:0]    w_q_addr;
    logic [TIME_BITS-1:0] w_q_time;
    logic                 w_q_pop;

    // Registers sit on word boundaries; the upper address bits pick one.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W - 2)'(REG_MIU));
    assign prdata   = APB_DATA_W'(r_miu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miu <= MIU_RESET;
        end else if (w_cfg_wr) begin
            r_miu <= pwdata[MIU_W-1:0];
        end
    end

    fsmk_front #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES),
        .TIME_BITS    (TIME_BITS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_job               (i_job),
        .i_machine           (i_machine),
        .i_time_value        (i_time_value),
        .i_first_in_sequence (i_first_in_sequence),
        .i_last_in_sequence  (i_last_in_sequence),
        .o_q_vld             (w_q_vld),
        .o_q_ctl             (w_q_ctl),
        .o_q_addr            (w_q_addr),
        .o_q_time            (w_q_time),
        .i_q_pop             (w_q_pop)
    );

    fsmk_back #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES),
        .TIME_BITS    (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_vld     (w_q_vld),
        .i_q_ctl     (w_q_ctl),
        .i_q_addr    (w_q_addr),
        .i_q_time    (w_q_time),
        .o_q_pop     (w_q_pop),
        .i_miu       (r_miu),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_makespan  (o_makespan)
    );

endmodule

// ===== rtl/core/fsmk_checker.sv =====
// Port-level checker for the makespan block, bound to its top level.
// Depends on fsmk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsmk_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [fsmk_pkg::ROW_BITS-1:0]     o_makespan,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [fsmk_pkg::APB_ADDR_W-1:0]   paddr,
    input logic [fsmk_pkg::APB_DATA_W-1:0]   pwdata,
    input logic [fsmk_pkg::APB_DATA_W-1:0]   prdata,
    input logic                              pready
);
    import fsmk_pkg::*;

    logic w_cfg_wr;
    logic w_out_stall;

    assign w_cfg_wr    = psel && penable && pwrite && pready
                         && (paddr[APB_ADDR_W-1:2] == '0);
    assign w_out_stall = o_out_valid && !i_out_ready;

    // Reset leaves the queue empty and the result register vacant.
    `FSMK_ASSERT_ALWAYS(a_reset_ready, i_clk, !i_rst_n |=> o_in_ready, "ready low after reset")
    `FSMK_ASSERT_ALWAYS(a_reset_no_out, i_clk, !i_rst_n |=> !o_out_valid, "result after reset")

    // A held result keeps its value until it is transferred.
    `FSMK_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> o_out_valid && $stable(o_makespan), "result moved")

    // A write to the machine count register reads back on the next cycle.
    `FSMK_ASSERT(a_cfg_readback, i_clk, i_rst_n, w_cfg_wr |=> prdata == 32'($past(pwdata[MIU_W-1:0])), "readback")

endmodule

bind flow_shop_makespan fsmk_checker u_fsmk_checker (.*);

// ===== sim/makespan_checker.sv =====
// Checker for the flow-shop makespan block: watches the input, output and APB channels.
// It keeps its own time table, completion row and machine count, and compares every makespan.
// Depends on fsmk_pkg.
`timescale 1ns / 1ps

module makespan_checker
    import fsmk_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_func,
    input  logic [JOB_FIELD_W-1:0]  i_job,
    input  logic [MACH_FIELD_W-1:0] i_machine,
    input  logic [TIME_FIELD_W-1:0] i_time_value,
    input  logic                    i_first,
    input  logic                    i_last,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [ROW_BITS-1:0]     i_makespan,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [APB_ADDR_W-1:0]   i_paddr,
    input  logic [APB_DATA_W-1:0]   i_pwdata,
    input  logic [APB_DATA_W-1:0]   i_prdata,
    input  logic                    i_pready,
    output int                      o_fail_count,
    output int                      o_pending
);

    logic [TIME_FIELD_W-1:0] proc_time [0:MAX_JOBS_DEF*MAX_MACHINES_DEF-1];
    logic [ROW_BITS-1:0]     finish_row [0:MAX_MACHINES_DEF-1];
    logic [MIU_W-1:0]        machine_count;
    logic [ROW_BITS-1:0]     makespan_due [$];
    int                      fail_count = 0;
    int                      pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // A count of zero behaves as one machine, anything above the row length as the full row.
    function automatic int active_machines();
        if (machine_count == 0) return 1;
        if (machine_count > MAX_MACHINES_DEF) return MAX_MACHINES_DEF;
        return int'(machine_count);
    endfunction

    // One job walks the row: each machine starts once both it and the previous machine are free.
    task automatic advance_completion_row(input logic [JOB_FIELD_W-1:0] job,
                                          input logic first_flag, input logic last_flag);
        int                  count;
        logic [ROW_BITS-1:0] prev;
        logic [ROW_BITS-1:0] base;
        logic [ROW_BITS:0]   total;
        if (first_flag) begin
            foreach (finish_row[k]) finish_row[k] = '0;
        end
        count = active_machines();
        prev  = '0;
        for (int j = 0; j < count; j++) begin
            base  = (finish_row[j] > prev) ? finish_row[j] : prev;
            total = {1'b0, base} + (ROW_BITS + 1)'(proc_time[{job, MACH_FIELD_W'(j)}]);
            if (total > {1'b0, ROW_MAX}) begin
                total = {1'b0, ROW_MAX};
            end
            finish_row[j] = total[ROW_BITS-1:0];
            prev          = total[ROW_BITS-1:0];
        end
        if (last_flag) begin
            makespan_due = {makespan_due, prev};
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (finish_row[k]) finish_row[k] = '0;
            machine_count = MIU_RESET;
            makespan_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == APB_ADDR_W'(4 * REG_MIU)) begin
                if (i_pwrite) begin
                    machine_count = i_pwdata[MIU_W-1:0];
                end else if (i_prdata !== APB_DATA_W'(machine_count)) begin
                    note_mismatch("machine count readback", APB_DATA_W'(machine_count),
                                  i_prdata);
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (makespan_due.size() == 0) begin
                    note_mismatch("makespan with none outstanding", '0, 32'(i_makespan));
                end else begin
                    if (i_makespan !== makespan_due[0]) begin
                        note_mismatch("makespan", 32'(makespan_due[0]), 32'(i_makespan));
                    end
                    void'(makespan_due.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (t_func'(i_func) == FUNC_WRITE) begin
                    proc_time[{i_job, i_machine}] = i_time_value;
                end else begin
                    advance_completion_row(i_job, i_first, i_last);
                end
            end
        end
        pending_count = makespan_due.size();
    end

endmodule

// ===== sim/tb_flow_shop_makespan.sv =====
// Testbench top for the flow-shop makespan block: clock, reset, stimulus and verdict.
// Depends on fsmk_pkg, flow_shop_makespan and makespan_checker; the checker does all comparing.
`timescale 1ns / 1ps

module tb_flow_shop_makespan;
    import fsmk_pkg::*;

    localparam int NUM_PHASES = 9;
    // Cycles allowed after the last makespan for any item still working inside the block.
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_func;
    logic [JOB_FIELD_W-1:0]  i_job;
    logic [MACH_FIELD_W-1:0] i_machine;
    logic [TIME_FIELD_W-1:0] i_time_value;
    logic                    i_first_in_sequence;
    logic                    i_last_in_sequence;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [ROW_BITS-1:0]     o_makespan;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    int                      fail_count;
    int                      pending;

    // Which (job, machine) entries of the time table hold a value, so that a job item never
    // reads an entry that was never written.
    logic [MAX_MACHINES_DEF-1:0] written [0:MAX_JOBS_DEF-1];
    int                          eff_machines;
    int                          fill_job = -1;
    int                          seq_left = 0;
    // In the quiet phase neither side idles; the hold request arms the long output stall.
    bit                          quiet;
    bit                          hold_req;

    flow_shop_makespan i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_func              (i_func),
        .i_job               (i_job),
        .i_machine           (i_machine),
        .i_time_value        (i_time_value),
        .i_first_in_sequence (i_first_in_sequence),
        .i_last_in_sequence  (i_last_in_sequence),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_makespan          (o_makespan),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    makespan_checker makespan_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_job        (i_job),
        .i_machine    (i_machine),
        .i_time_value (i_time_value),
        .i_first      (i_first_in_sequence),
        .i_last       (i_last_in_sequence),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_makespan   (o_makespan),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // A hard ceiling on the run.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // The receiver. It takes results at random, with bursts of stall, and once holds off for a
    // long stretch while a makespan is waiting, so that the block backs up and stops taking
    // items. In the quiet phase it takes every result at once.
    initial begin
        bit held_off;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held_off && o_out_valid) begin
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // The effective machine count: zero acts as one and anything past the row as the row.
    function automatic int clamp_machines(input int count);
        if (count < 1) return 1;
        if (count > MAX_MACHINES_DEF) return MAX_MACHINES_DEF;
        return count;
    endfunction

    // A job may run once every machine in use has a processing time for it.
    function automatic bit job_ready(input int job);
        logic [MAX_MACHINES_DEF-1:0] mask;
        mask = (eff_machines >= MAX_MACHINES_DEF) ? '1
             : (MAX_MACHINES_DEF'(1) << eff_machines) - 1'b1;
        return (written[job] & mask) == mask;
    endfunction

    // Processing times lean towards the two extremes so that both ends get plenty of use.
    function automatic logic [TIME_FIELD_W-1:0] pick_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return TIME_FIELD_W'($urandom);
        endcase
    endfunction

    // One transfer on the input channel. An optional idle burst comes first; the payload is
    // then held with valid high until the block takes it. Returns on the falling edge after
    // the transfer, where the next item may be driven straight away.
    task automatic send_item(input t_func func, input logic [JOB_FIELD_W-1:0] job,
                             input logic [MACH_FIELD_W-1:0] mach,
                             input logic [TIME_FIELD_W-1:0] tval,
                             input logic first_flag, input logic last_flag);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_func              <= func;
        i_job               <= job;
        i_machine           <= mach;
        i_time_value        <= tval;
        i_first_in_sequence <= first_flag;
        i_last_in_sequence  <= last_flag;
        if (func == FUNC_WRITE) begin
            written[job][mach] = 1'b1;
        end
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // One APB access: a setup phase, then an access phase that completes on pready.
    task automatic apb_access(input bit is_write, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(4 * REG_MIU);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Stops offering items and waits until every makespan has come out, then lets the block
    // finish any write or mid-sequence job that produces nothing visible.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One random item. Most items are job items inside well-formed sequences of one to eight
    // jobs; a few sequences lose their start flag or their end flag, and a few restart midway.
    // Writes either fill in the table for a job that is not yet usable or overwrite at random.
    task automatic random_item();
        int     ready_jobs[$];
        int     open_jobs[$];
        int     mach;
        int     job;
        logic   first_flag;
        logic   last_flag;
        for (int j = 0; j < MAX_JOBS_DEF; j++) begin
            if (job_ready(j)) ready_jobs = {ready_jobs, j};
            else open_jobs = {open_jobs, j};
        end
        if (ready_jobs.size() == 0 || $urandom_range(0, 3) == 0) begin
            if (ready_jobs.size() < 6 && open_jobs.size() > 0) begin
                if (fill_job < 0 || job_ready(fill_job)) begin
                    fill_job = open_jobs[$urandom_range(0, open_jobs.size() - 1)];
                end
                mach = 0;
                while (written[fill_job][mach]) mach++;
                send_item(FUNC_WRITE, JOB_FIELD_W'(fill_job), MACH_FIELD_W'(mach), pick_time(),
                          1'($urandom), 1'($urandom));
            end else begin
                send_item(FUNC_WRITE, JOB_FIELD_W'($urandom), MACH_FIELD_W'($urandom),
                          pick_time(), 1'($urandom), 1'($urandom));
            end
        end else begin
            job = ready_jobs[$urandom_range(0, ready_jobs.size() - 1)];
            if (seq_left == 0) begin
                first_flag = ($urandom_range(0, 9) != 0);
                seq_left   = $urandom_range(1, 8);
            end else begin
                first_flag = ($urandom_range(0, 19) == 0);
            end
            seq_left--;
            last_flag = (seq_left == 0) && ($urandom_range(0, 14) != 0);
            send_item(FUNC_JOB, JOB_FIELD_W'(job), MACH_FIELD_W'($urandom), TIME_FIELD_W'($urandom),
                      first_flag, last_flag);
        end
    endtask

    // The opening items, run with two machines so that a job needs only two table entries.
    // They cover both extremes of every field, a write whose sequence flags must be ignored,
    // a single-job sequence, a sequence that carries on without a start flag, a sequence cut
    // short by a fresh start, and a rewrite of an entry already in use.
    task automatic directed_items();
        send_item(FUNC_WRITE, 6'd0,  4'd0,  16'hFFFF, 1'b1, 1'b1);
        send_item(FUNC_WRITE, 6'd0,  4'd1,  16'h0000, 1'b0, 1'b0);
        send_item(FUNC_WRITE, 6'd63, 4'd0,  16'h0000, 1'b1, 1'b0);
        send_item(FUNC_WRITE, 6'd63, 4'd1,  16'hFFFF, 1'b0, 1'b1);
        send_item(FUNC_WRITE, 6'd63, 4'd15, 16'hA5A5, 1'b0, 1'b0);
        send_item(FUNC_JOB,   6'd0,  4'd15, 16'hFFFF, 1'b1, 1'b1);
        send_item(FUNC_JOB,   6'd63, 4'd0,  16'h0000, 1'b1, 1'b0);
        send_item(FUNC_JOB,   6'd0,  4'd15, 16'h5A5A, 1'b0, 1'b0);
        send_item(FUNC_JOB,   6'd63, 4'd0,  16'hFFFF, 1'b0, 1'b1);
        send_item(FUNC_JOB,   6'd0,  4'd0,  16'h0000, 1'b0, 1'b1);
        send_item(FUNC_JOB,   6'd63, 4'd7,  16'h1234, 1'b1, 1'b0);
        send_item(FUNC_JOB,   6'd0,  4'd0,  16'h0000, 1'b1, 1'b1);
        send_item(FUNC_WRITE, 6'd0,  4'd0,  16'h0001, 1'b1, 1'b0);
        send_item(FUNC_JOB,   6'd0,  4'd0,  16'h0000, 1'b1, 1'b1);
    endtask

    // A sequence long enough to drive the completion row into saturation: one job with the
    // largest time on all sixteen machines, repeated past the point where the last
    // machine's completion reaches the ceiling. The sequence is ended and then continued
    // without a start flag twice on the way, so that the climb is visible.
    task automatic saturating_sequence();
        int job;
        job = $urandom_range(0, MAX_JOBS_DEF - 1);
        for (int m = 0; m < MAX_MACHINES_DEF; m++) begin
            send_item(FUNC_WRITE, JOB_FIELD_W'(job), MACH_FIELD_W'(m), '1, 1'b0, 1'b0);
        end
        for (int n = 0; n < 130; n++) begin
            send_item(FUNC_JOB, JOB_FIELD_W'(job), MACH_FIELD_W'($urandom),
                      TIME_FIELD_W'($urandom), n == 0, n == 59 || n == 119 || n == 129);
        end
        seq_left = 0;
    endtask

    initial begin
        // Machine count and item count for each phase. A negative count means a random
        // setting between two and fifteen. Counts outside the legal range are included on
        // purpose, as is the largest value the register can hold.
        int phase_miu[NUM_PHASES]   = '{2, 16, 1, 0, 31, 16, -1, 17, 16};
        int phase_items[NUM_PHASES] = '{80, 100, 100, 60, 60, 40, 70, 60, 120};
        int miu;

        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_func              = FUNC_WRITE;
        i_job               = '0;
        i_machine           = '0;
        i_time_value        = '0;
        i_first_in_sequence = 1'b0;
        i_last_in_sequence  = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        foreach (written[j]) written[j] = '0;
        eff_machines = MAX_MACHINES_DEF;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The reset value of the machine count is read back before anything is written.
        apb_access(1'b0, '0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) drain();
            miu = (phase_miu[p] < 0) ? $urandom_range(2, 15) : phase_miu[p];
            apb_access(1'b1, APB_DATA_W'(miu));
            apb_access(1'b0, '0);
            eff_machines = clamp_machines(miu);
            seq_left     = 0;
            // The long stall is armed in the single-machine phase, where makespans are frequent.
            hold_req = (p == 2);
            quiet    = (p == NUM_PHASES - 1);
            if (p == 0) directed_items();
            if (p == 5) saturating_sequence();
            repeat (phase_items[p]) random_item();
        end
        drain();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/fsmk_pkg.sv
rtl/core/fsmk_ram.sv
rtl/core/fsmk_front.sv
rtl/core/fsmk_back.sv
rtl/core/flow_shop_makespan.sv
rtl/core/fsmk_checker.sv
sim/makespan_checker.sv
sim/tb_flow_shop_makespan.sv
